// File: hdl/kns_pkg.sv
// Shared types and constants for the nearest distance select unit.
`default_nettype none

package kns_pkg;

  localparam int MODE_W     = 2;
  localparam int IDX_W      = 5;
  localparam int FEAT_W     = 16;
  localparam int ID_MAX_W   = 16;
  localparam int MAG_W      = 16;
  localparam int SQ_W       = 32;
  localparam int DIST_W     = 37;
  localparam int RANK_W     = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REF    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_REF,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [IDX_W-1:0]          index;
    logic signed [FEAT_W-1:0]  value;
    logic [ID_MAX_W-1:0]       id;
    logic                      last;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/knn_nearest_distance_select_unit.sv
// Load/reference transactions: one per cycle unless stalled; list update via queue, s1-s3, ins.
// Reference feature path: queue, query memory read, subtract, square, accumulate, insert.
// Report transaction: waits for the distance pipeline to drain, sets rep_active on pop, then K
// results out of registered outputs, one per cycle unless the output stalls.
// Reset clears queue, pipeline, accumulator, fill count and report state; query memory and
// list contents are not cleared.
`default_nettype none

module knn_nearest_distance_select_unit #(
  parameter int DIM      = 26,
  parameter int K        = 5,
  parameter int ID_WIDTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [kns_pkg::MODE_W-1:0]        mode,
  input  wire logic [kns_pkg::IDX_W-1:0]         feature_index,
  input  wire logic signed [kns_pkg::FEAT_W-1:0] feature_value,
  input  wire logic [ID_WIDTH-1:0]               reference_id,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [kns_pkg::RANK_W-1:0]             rank,
  output logic [ID_WIDTH-1:0]                    neighbour_id,
  output logic [kns_pkg::DIST_W-1:0]             distance_sq,
  output logic                                   entry_valid,
  output logic                                   last_result
);

  logic          q_full;
  logic          push;
  kns_pkg::cmd_t push_cmd;
  logic          pop;
  kns_pkg::cmd_t head;
  logic          not_empty;

  kns_front #(
    .DIM      (DIM),
    .ID_WIDTH (ID_WIDTH)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .feature_index (feature_index),
    .feature_value (feature_value),
    .reference_id  (reference_id),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  kns_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  kns_back #(
    .DIM      (DIM),
    .K        (K),
    .ID_WIDTH (ID_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .not_empty    (not_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rank         (rank),
    .neighbour_id (neighbour_id),
    .distance_sq  (distance_sq),
    .entry_valid  (entry_valid),
    .last_result  (last_result)
  );

endmodule

`default_nettype wire

// File: hdl/kns_front.sv
// Front end: accepts input transactions, drops meaningless ones, builds queue commands.
`default_nettype none

module kns_front #(
  parameter int DIM      = 26,
  parameter int ID_WIDTH = 8
) (
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [kns_pkg::MODE_W-1:0]        mode,
  input  wire logic [kns_pkg::IDX_W-1:0]         feature_index,
  input  wire logic signed [kns_pkg::FEAT_W-1:0] feature_value,
  input  wire logic [ID_WIDTH-1:0]               reference_id,
  input  wire logic                              q_full,
  output logic                                   push,
  output kns_pkg::cmd_t                          push_cmd
);

  logic accept;
  logic idx_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign idx_ok   = 32'(feature_index) < DIM;

  always_comb begin
    push_cmd.kind  = kns_pkg::CMD_LOAD;
    push_cmd.index = feature_index;
    push_cmd.value = feature_value;
    push_cmd.id    = kns_pkg::ID_MAX_W'(reference_id);
    push_cmd.last  = 32'(feature_index) == (DIM - 1);
    push           = 1'b0;
    case (mode)
      kns_pkg::MODE_LOAD: begin
        push_cmd.kind = kns_pkg::CMD_LOAD;
        push          = accept && idx_ok;
      end
      kns_pkg::MODE_REF: begin
        push_cmd.kind = kns_pkg::CMD_REF;
        push          = accept && idx_ok;
      end
      kns_pkg::MODE_REPORT: begin
        push_cmd.kind = kns_pkg::CMD_REPORT;
        push          = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/kns_queue.sv
// Short command queue between the front end and the execution back end.
`default_nettype none

module kns_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire kns_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output kns_pkg::cmd_t      head,
  output logic               not_empty
);

  kns_pkg::cmd_t                 slots [kns_pkg::QUEUE_DEPTH];
  logic [kns_pkg::QPTR_W-1:0]    wr_ptr;
  logic [kns_pkg::QPTR_W-1:0]    rd_ptr;
  logic [kns_pkg::QPTR_W:0]      count;

  assign full      = count == (kns_pkg::QPTR_W + 1)'(kns_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

// File: hdl/kns_back.sv
// Back end: query memory, distance pipeline, sorted nearest list and report sequencer.
`default_nettype none

module kns_back #(
  parameter int DIM      = 26,
  parameter int K        = 5,
  parameter int ID_WIDTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire kns_pkg::cmd_t                 head,
  input  wire logic                          not_empty,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [kns_pkg::RANK_W-1:0]         rank,
  output logic [ID_WIDTH-1:0]                neighbour_id,
  output logic [kns_pkg::DIST_W-1:0]         distance_sq,
  output logic                               entry_valid,
  output logic                               last_result
);

  localparam int QA_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AE_W = QA_W + kns_pkg::IDX_W;
  localparam int RK_W = (K > 1) ? $clog2(K) : 1;
  localparam int FC_W = $clog2(K + 1);
  localparam int DW   = kns_pkg::DIST_W;

  // query memory
  logic signed [kns_pkg::FEAT_W-1:0] qmem [DIM];
  logic signed [kns_pkg::FEAT_W-1:0] q_rd;
  logic [AE_W-1:0]                   addr_ext;
  logic [QA_W-1:0]                   addr;

  // distance pipeline
  logic                              s1_vld, s2_vld, s3_vld, ins_vld;
  logic signed [kns_pkg::FEAT_W-1:0] s1_val;
  logic [ID_WIDTH-1:0]               s1_id, s2_id, s3_id, ins_id;
  logic                              s1_last, s2_last, s3_last;
  logic [kns_pkg::MAG_W-1:0]         s2_mag;
  logic [kns_pkg::SQ_W-1:0]          s3_sq;
  logic [DW-1:0]                     acc;
  logic [DW-1:0]                     ins_dist;
  logic signed [kns_pkg::FEAT_W:0]   diff;
  logic [kns_pkg::FEAT_W:0]          diff_neg;
  logic [kns_pkg::MAG_W-1:0]         mag;
  logic [DW:0]                       sum;
  logic [DW-1:0]                     sum_sat;
  logic                              pipe_empty;

  // nearest list
  logic [DW-1:0]                     d_list  [K];
  logic [ID_WIDTH-1:0]               id_list [K];
  logic [DW-1:0]                     sh_d    [K];
  logic [ID_WIDTH-1:0]               sh_id   [K];
  logic [K-1:0]                      le;
  logic [K-1:0]                      prev_le;
  logic [FC_W-1:0]                   filled;

  // report
  logic                              rep_active;
  logic [RK_W-1:0]                   rep_rank;
  logic                              rep_last;
  logic                              rep_entry;
  logic                              out_load;

  assign addr_ext   = AE_W'(head.index);
  assign addr       = addr_ext[QA_W-1:0];
  assign pipe_empty = !(s1_vld || s2_vld || s3_vld || ins_vld);
  assign pop        = not_empty && !rep_active &&
                      (head.kind != kns_pkg::CMD_REPORT || pipe_empty);

  assign diff     = {s1_val[kns_pkg::FEAT_W-1], s1_val} - {q_rd[kns_pkg::FEAT_W-1], q_rd};
  assign diff_neg = -diff;
  assign mag      = diff[kns_pkg::FEAT_W] ? diff_neg[kns_pkg::MAG_W-1:0]
                                          : diff[kns_pkg::MAG_W-1:0];
  assign sum      = {1'b0, acc} + (DW + 1)'(s3_sq);
  assign sum_sat  = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];

  // list slots at or below the new distance form a prefix; the new entry lands after it
  always_comb begin
    for (int i = 0; i < K; i++) begin
      le[i] = (FC_W'(i) < filled) && (d_list[i] <= ins_dist);
    end
    prev_le[0] = 1'b1;
    for (int i = 1; i < K; i++) begin
      prev_le[i] = le[i-1];
    end
  end

  for (genvar g = 0; g < K; g++) begin : g_shift
    if (g == 0) begin : g_first
      assign sh_d[g]  = ins_dist;
      assign sh_id[g] = ins_id;
    end else begin : g_rest
      assign sh_d[g]  = d_list[g-1];
      assign sh_id[g] = id_list[g-1];
    end
  end

  assign rep_last  = rep_rank == RK_W'(K - 1);
  assign rep_entry = FC_W'(rep_rank) < filled;
  assign out_load  = rep_active && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (pop && head.kind == kns_pkg::CMD_LOAD) qmem[addr] <= head.value;
    q_rd <= qmem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld     <= 1'b0;
      s2_vld     <= 1'b0;
      s3_vld     <= 1'b0;
      ins_vld    <= 1'b0;
      acc        <= '0;
      filled     <= '0;
      rep_active <= 1'b0;
      rep_rank   <= '0;
      out_valid  <= 1'b0;
    end else begin
      s1_vld  <= pop && head.kind == kns_pkg::CMD_REF;
      s2_vld  <= s1_vld;
      s3_vld  <= s2_vld;
      ins_vld <= s3_vld && s3_last;
      if (s3_vld) acc <= s3_last ? '0 : sum_sat;
      if (ins_vld && filled != FC_W'(K)) filled <= filled + 1'b1;

      if (pop && head.kind == kns_pkg::CMD_REPORT) begin
        rep_active <= 1'b1;
        rep_rank   <= '0;
      end else if (out_load) begin
        if (rep_last) begin
          rep_active <= 1'b0;
          filled     <= '0;
        end else begin
          rep_rank <= rep_rank + 1'b1;
        end
      end

      if (out_load)        out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s1_val   <= head.value;
    s1_id    <= head.id[ID_WIDTH-1:0];
    s1_last  <= head.last;
    s2_mag   <= mag;
    s2_id    <= s1_id;
    s2_last  <= s1_last;
    s3_sq    <= s2_mag * s2_mag;
    s3_id    <= s2_id;
    s3_last  <= s2_last;
    ins_dist <= sum_sat;
    ins_id   <= s3_id;
    if (ins_vld) begin
      for (int i = 0; i < K; i++) begin
        if (!le[i]) begin
          d_list[i]  <= prev_le[i] ? ins_dist : sh_d[i];
          id_list[i] <= prev_le[i] ? ins_id : sh_id[i];
        end
      end
    end
    if (out_load) begin
      rank         <= kns_pkg::RANK_W'(rep_rank);
      neighbour_id <= rep_entry ? id_list[rep_rank] : '0;
      distance_sq  <= rep_entry ? d_list[rep_rank] : '0;
      entry_valid  <= rep_entry;
      last_result  <= rep_last;
    end
  end

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= FC_W'(K))
    else $error("nearest list fill count above K");

  a_report_drained: assert property (@(posedge clk) disable iff (rst)
    $rose(rep_active) |-> pipe_empty)
    else $error("report started with distance pipeline busy");

  a_no_insert_in_report: assert property (@(posedge clk) disable iff (rst)
    ins_vld |-> !rep_active)
    else $error("list insertion during report");

  a_last_rank: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_result |-> rank == kns_pkg::RANK_W'(K - 1))
    else $error("last result flagged on wrong rank");

endmodule

`default_nettype wire

// File: tb/sv/knn_nearest_distance_select_unit_tb.sv
// Self-checking testbench for the k-nearest distance select unit, with a scoreboard class.
module knn_nearest_distance_select_unit_tb;
  import kns_pkg::*;

  localparam int DIM = 26;
  localparam int K = 5;
  localparam int ID_WIDTH = 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};
  localparam int RANDOM_ITEMS = 270;
  localparam int MIN_REPORTS = 6;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [RANK_W-1:0]   rank;
    logic [ID_WIDTH-1:0] id;
    logic [DIST_W-1:0]   dist_sq;
    logic                valid;
    logic                last;
  } rank_entry_t;

  class nearest_list_tracker;
    logic signed [FEAT_W-1:0] query [DIM];
    logic [DIST_W-1:0]        acc;
    logic [DIST_W-1:0]        list_dist [K];
    logic [ID_WIDTH-1:0]      ids [K];
    int                       filled;
    rank_entry_t              expected_ranks [$];
    int                       mismatches;
    int                       inputs_taken;
    int                       ignored;
    int                       reports;
    int                       checked;

    function new();
      acc = '0;
      filled = 0;
      mismatches = 0;
      inputs_taken = 0;
      ignored = 0;
      reports = 0;
      checked = 0;
    endfunction

    // Accepted input transaction: update the query, the running distance or emit the list.
    function void take_input(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
                             logic signed [FEAT_W-1:0] v, logic [ID_WIDTH-1:0] id);
      logic [FEAT_W:0]     diff;
      logic [FEAT_W:0]     mag;
      logic [2*FEAT_W+1:0] sq;
      logic [DIST_W:0]     sum;
      int                  p;
      int                  i;
      rank_entry_t         e;
      inputs_taken++;
      case (m)
        MODE_LOAD: begin
          if (idx < DIM) query[idx] = v;
          else ignored++;
        end
        MODE_REF: begin
          if (idx >= DIM) begin
            ignored++;
          end else begin
            diff = {v[FEAT_W-1], v} - {query[idx][FEAT_W-1], query[idx]};
            mag = diff[FEAT_W] ? -diff : diff;
            sq = mag * mag;
            sum = acc + sq;
            acc = (sum > DIST_SAT) ? DIST_SAT : sum[DIST_W-1:0];
            if (idx == DIM - 1) begin
              // ties keep the earlier reference ahead
              p = 0;
              while (p < filled && list_dist[p] <= acc) p++;
              if (p < K) begin
                i = (filled < K) ? filled : K - 1;
                while (i > p) begin
                  list_dist[i] = list_dist[i-1];
                  ids[i] = ids[i-1];
                  i--;
                end
                list_dist[p] = acc;
                ids[p] = id;
                if (filled < K) filled++;
              end
              acc = '0;
            end
          end
        end
        MODE_REPORT: begin
          reports++;
          for (int r = 0; r < K; r++) begin
            e.rank = RANK_W'(r);
            e.valid = (r < filled);
            e.id = e.valid ? ids[r] : '0;
            e.dist_sq = e.valid ? list_dist[r] : '0;
            e.last = (r == K - 1);
            expected_ranks.push_back(e);
          end
          filled = 0;
        end
        default: ignored++;
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_rank(rank_entry_t got);
      rank_entry_t want;
      if (expected_ranks.size() == 0) begin
        $error("result transaction with nothing expected: rank %0d", got.rank);
        mismatches++;
        return;
      end
      want = expected_ranks.pop_front();
      checked++;
      compare_field("rank", want.rank, got.rank);
      compare_field("neighbour_id", want.id, got.id);
      compare_field("distance_sq", want.dist_sq, got.dist_sq);
      compare_field("entry_valid", want.valid, got.valid);
      compare_field("last_result", want.last, got.last);
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [MODE_W-1:0]        mode = '0;
  logic [IDX_W-1:0]         feature_index = '0;
  logic signed [FEAT_W-1:0] feature_value = '0;
  logic [ID_WIDTH-1:0]      reference_id = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [RANK_W-1:0]        rank;
  logic [ID_WIDTH-1:0]      neighbour_id;
  logic [DIST_W-1:0]        distance_sq;
  logic                     entry_valid;
  logic                     last_result;

  nearest_list_tracker      tracker;
  bit                       quiet = 1'b0;
  bit                       gap_on = 1'b1;
  bit                       stall_on = 1'b1;
  int                       stall_left = 0;
  int                       cycles = 0;
  int                       fed_items = 0;
  logic [IDX_W-1:0]         vec_idx [$];
  logic signed [FEAT_W-1:0] vec_val [$];

  knn_nearest_distance_select_unit #(
    .DIM(DIM),
    .K(K),
    .ID_WIDTH(ID_WIDTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .feature_index(feature_index),
    .feature_value(feature_value),
    .reference_id(reference_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rank(rank),
    .neighbour_id(neighbour_id),
    .distance_sq(distance_sq),
    .entry_valid(entry_valid),
    .last_result(last_result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("knn_nearest_distance_select_unit_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    rank_entry_t got;
    if (!rst) begin
      if (in_valid && !in_stall)
        tracker.take_input(mode, feature_index, feature_value, reference_id);
      if (out_valid && !out_stall) begin
        got = '{rank, neighbour_id, distance_sq, entry_valid, last_result};
        tracker.check_rank(got);
      end
    end
  end

  // output back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && stall_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
                           input logic signed [FEAT_W-1:0] v,
                           input logic [ID_WIDTH-1:0] id);
    if (gap_on && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    feature_index <= idx;
    feature_value <= v;
    reference_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // items the block drops: unused mode, index past the descriptor
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_item(MODE_UNUSED, IDX_W'($urandom), FEAT_W'($urandom), ID_WIDTH'($urandom));
      1: send_item(MODE_LOAD, IDX_W'($urandom_range(DIM, 31)), FEAT_W'($urandom),
                   ID_WIDTH'($urandom));
      default: send_item(MODE_REF, IDX_W'($urandom_range(DIM, 31)), FEAT_W'($urandom),
                         ID_WIDTH'($urandom));
    endcase
  endtask

  task automatic send_vector(input logic [ID_WIDTH-1:0] id, input bit noisy);
    for (int n = 0; n < vec_idx.size(); n++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_noise();
      send_item(MODE_REF, vec_idx[n], vec_val[n], id);
      fed_items++;
    end
  endtask

  task automatic await_drain();
    in_valid <= 1'b0;
    while (tracker.expected_ranks.size() != 0) @(negedge clk);
  endtask

  // mix of full-range, corner and near-zero values so distances tie and stay small
  function automatic logic signed [FEAT_W-1:0] pick_feature();
    case ($urandom_range(0, 3))
      0, 1: return FEAT_W'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0001;
          default: return 16'shFFFF;
        endcase
      end
      default: return FEAT_W'($urandom_range(0, 8)) - 16'sd4;
    endcase
  endfunction

  initial begin
    logic signed [FEAT_W-1:0] near_val [6];
    logic [ID_WIDTH-1:0]      near_id [6];
    int                       episode;
    int                       reps;
    tracker = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // empty list, dropped items, then the query with corner values
    send_item(MODE_REPORT, '0, '0, '0);
    send_item(MODE_UNUSED, 5'd3, 16'sh1234, 8'h12);
    send_item(MODE_LOAD, 5'd31, 16'sh8000, '0);
    send_item(MODE_REF, 5'd26, 16'sh7FFF, 8'hFF);
    for (int i = 0; i < DIM; i++)
      send_item(MODE_LOAD, IDX_W'(i), i[0] ? 16'sh7FFF : 16'sh8000, '0);

    // opposite corner on every feature gives the largest distance
    vec_idx = {};
    vec_val = {};
    for (int i = 0; i < DIM; i++) begin
      vec_idx.push_back(IDX_W'(i));
      vec_val.push_back(i[0] ? 16'sh8000 : 16'sh7FFF);
    end
    send_vector(8'hFF, 1'b0);

    // single last-feature vectors: ties, a shift that pushes out the far entry, a drop on full
    near_val = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFD, 16'sh7FFE, 16'sh7FFD, 16'sh7FFD};
    near_id = '{8'h00, 8'h01, 8'hAA, 8'h55, 8'h3C, 8'h11};
    for (int i = 0; i < 6; i++) begin
      vec_idx = '{IDX_W'(DIM - 1)};
      vec_val = '{near_val[i]};
      send_vector(near_id[i], 1'b0);
    end
    send_item(MODE_REPORT, 5'd31, 16'shFFFF, 8'hFF);

    // running sum survives a report and a query write
    send_item(MODE_REF, 5'd0, 16'sh0000, 8'h80);
    send_item(MODE_REPORT, '0, '0, '0);
    send_item(MODE_LOAD, 5'd0, 16'sh8000, '0);
    send_item(MODE_REF, IDX_W'(DIM - 1), 16'sh7FFF, 8'h80);

    fed_items = 0;
    episode = 0;
    while (fed_items < RANDOM_ITEMS || episode < MIN_REPORTS) begin
      quiet = fed_items > RANDOM_ITEMS - 70;
      gap_on = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(MODE_LOAD, IDX_W'($urandom_range(0, DIM - 1)), pick_feature(),
                    ID_WIDTH'($urandom));
          fed_items++;
        end
      end
      reps = $urandom_range(1, 8);
      for (int v = 0; v < reps; v++) begin
        // otherwise resend the previous vector under a new id to force a tie
        if ($urandom_range(0, 3) != 0) begin
          vec_idx = {};
          vec_val = {};
          if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < DIM; i++) begin
              vec_idx.push_back(IDX_W'(i));
              vec_val.push_back(pick_feature());
            end
          end else begin
            repeat ($urandom_range(0, 3)) begin
              vec_idx.push_back(IDX_W'($urandom_range(0, DIM - 2)));
              vec_val.push_back(pick_feature());
            end
            vec_idx.push_back(IDX_W'(DIM - 1));
            vec_val.push_back(pick_feature());
          end
        end
        send_vector(ID_WIDTH'($urandom), 1'b1);
      end
      send_item(MODE_REPORT, IDX_W'($urandom), FEAT_W'($urandom), ID_WIDTH'($urandom));
      fed_items++;
      episode++;
      if (episode == 3) await_drain();
    end

    await_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("input transactions: %0d (%0d dropped by the block), list reports: %0d",
             tracker.inputs_taken, tracker.ignored, tracker.reports);
    $display("rank results checked: %0d, mismatches: %0d", tracker.checked,
             tracker.mismatches);
    if (tracker.mismatches == 0) $display("knn_nearest_distance_select_unit_tb OK");
    else $display("knn_nearest_distance_select_unit_tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
hdl/kns_pkg.sv
hdl/kns_front.sv
hdl/kns_queue.sv
hdl/kns_back.sv
hdl/knn_nearest_distance_select_unit.sv
tb/sv/knn_nearest_distance_select_unit_tb.sv
